// ===== design/body_to_world_goal_transform_unit_defines.svh =====
// ----------------------------------------------------------------------------
// body_to_world_goal_transform_unit_defines
// assertion macros used by bwgt_ctrl, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef BODY_TO_WORLD_GOAL_TRANSFORM_UNIT_DEFINES_SVH
`define BODY_TO_WORLD_GOAL_TRANSFORM_UNIT_DEFINES_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define BWGT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define BWGT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BWGT_ASSERT(lbl, prop, msg)
`define BWGT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/bwgt_pkg.sv =====
// ----------------------------------------------------------------------------
// bwgt_pkg
// types, constants and tables of the goal transform unit
// ----------------------------------------------------------------------------
package bwgt_pkg;

	localparam int CNT_W    = 5;
	localparam int IDX_W    = 5;
	localparam int NUM_PROD = 9;
	localparam int RF_W     = 35;   // full rotation entry, q28
	localparam int CV_W     = 38;   // cordic x / y
	localparam int CZ_W     = 28;   // cordic angle, q24
	localparam int ACC_W    = 64;

	localparam logic signed [RF_W-1:0] ONE_Q28 = RF_W'(64'sd268435456);
	localparam logic signed [17:0]     PI_Q13     = 18'sd25736;
	localparam logic signed [17:0]     TWO_PI_Q13 = 18'sd51472;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_QMUL  = 9'b000000010,
		S_MAT   = 9'b000000100,
		S_VMUL  = 9'b000001000,
		S_FIN   = 9'b000010000,
		S_CINIT = 9'b000100000,
		S_CITER = 9'b001000000,
		S_YAW   = 9'b010000000,
		S_HOLD  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic             load_pose;
		logic             load_step;
		logic             mul_go;
		logic             mul_vec;
		logic [IDX_W-1:0] idx;
		logic             mat;
		logic             fin;
		logic             cinit;
		logic             citer;
		logic             yaw;
		logic             load_out;
	} cmd_t;

	// arctangent of 2^-i in q24 radians
	function automatic logic signed [CZ_W-1:0] atan_q24(input logic [IDX_W-1:0] i);
		logic signed [CZ_W-1:0] v;
		case (i)
			5'd0:  v = 28'sd13176795;
			5'd1:  v = 28'sd7778716;
			5'd2:  v = 28'sd4110060;
			5'd3:  v = 28'sd2086331;
			5'd4:  v = 28'sd1047214;
			5'd5:  v = 28'sd524117;
			5'd6:  v = 28'sd262123;
			5'd7:  v = 28'sd131069;
			5'd8:  v = 28'sd65536;
			5'd9:  v = 28'sd32768;
			5'd10: v = 28'sd16384;
			5'd11: v = 28'sd8192;
			5'd12: v = 28'sd4096;
			5'd13: v = 28'sd2048;
			5'd14: v = 28'sd1024;
			5'd15: v = 28'sd512;
			5'd16: v = 28'sd256;
			5'd17: v = 28'sd128;
			5'd18: v = 28'sd64;
			5'd19: v = 28'sd32;
			5'd20: v = 28'sd16;
			5'd21: v = 28'sd8;
			5'd22: v = 28'sd4;
			5'd23: v = 28'sd2;
			default: v = '0;
		endcase
		return v;
	endfunction

	// quaternion operand pair of each product: xx yy zz xy xz yz wx wy wz
	function automatic logic [3:0] qpair(input logic [3:0] k);
		logic [3:0] v;
		case (k)
			4'd0: v = {2'd1, 2'd1};
			4'd1: v = {2'd2, 2'd2};
			4'd2: v = {2'd3, 2'd3};
			4'd3: v = {2'd1, 2'd2};
			4'd4: v = {2'd1, 2'd3};
			4'd5: v = {2'd2, 2'd3};
			4'd6: v = {2'd0, 2'd1};
			4'd7: v = {2'd0, 2'd2};
			4'd8: v = {2'd0, 2'd3};
			default: v = '0;
		endcase
		return v;
	endfunction

	// row and column of a matrix entry in row-major order
	function automatic logic [1:0] row_of(input logic [3:0] k);
		logic [1:0] v;
		case (k)
			4'd0, 4'd1, 4'd2: v = 2'd0;
			4'd3, 4'd4, 4'd5: v = 2'd1;
			default:          v = 2'd2;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] col_of(input logic [3:0] k);
		logic [1:0] v;
		case (k)
			4'd0, 4'd3, 4'd6: v = 2'd0;
			4'd1, 4'd4, 4'd7: v = 2'd1;
			default:          v = 2'd2;
		endcase
		return v;
	endfunction

endpackage

// ===== design/bwgt_in_if.sv =====
// ----------------------------------------------------------------------------
// bwgt_in_if
// input channel: odometry and move beats
// ----------------------------------------------------------------------------
interface bwgt_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic signed [31:0] pose_z;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [31:0] step_x;
	logic signed [31:0] step_y;
	logic signed [31:0] step_z;
	logic signed [15:0] step_yaw;

	modport source (output valid, command, pose_x, pose_y, pose_z, quat_w, quat_x, quat_y,
		quat_z, step_x, step_y, step_z, step_yaw, input ready);
	modport sink (input valid, command, pose_x, pose_y, pose_z, quat_w, quat_x, quat_y,
		quat_z, step_x, step_y, step_z, step_yaw, output ready);
endinterface

// ===== design/bwgt_out_if.sv =====
// ----------------------------------------------------------------------------
// bwgt_out_if
// output channel: world goal beats
// ----------------------------------------------------------------------------
interface bwgt_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] goal_x;
	logic signed [31:0] goal_y;
	logic signed [31:0] goal_z;
	logic signed [15:0] goal_yaw;
	logic               saturated;

	modport source (output valid, goal_x, goal_y, goal_z, goal_yaw, saturated, input ready);
	modport sink (input valid, goal_x, goal_y, goal_z, goal_yaw, saturated, output ready);
endinterface

// ===== design/bwgt_ctrl.sv =====
// ----------------------------------------------------------------------------
// bwgt_ctrl
// sequencer for products, matrix, cordic and output handoff
// ----------------------------------------------------------------------------
`include "body_to_world_goal_transform_unit_defines.svh"

module bwgt_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_command,
	output logic            in_ready,
	input  logic            out_ready,
	output logic            out_valid,
	output bwgt_pkg::cmd_t  cmd
);

	localparam logic [bwgt_pkg::CNT_W-1:0] LAST_MUL  = bwgt_pkg::CNT_W'(bwgt_pkg::NUM_PROD);
	localparam logic [bwgt_pkg::CNT_W-1:0] LAST_STEP = bwgt_pkg::CNT_W'(CORDIC_STEPS - 1);

	bwgt_pkg::state_t state_q, state_d;
	logic [bwgt_pkg::CNT_W-1:0] cnt_q;
	logic cnt_clr;
	logic out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.idx  = bwgt_pkg::IDX_W'(cnt_q);
		cnt_clr  = 1'b1;
		in_ready = 1'b0;
		case (state_q)
			bwgt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_command) begin
						cmd.load_step = 1'b1;
						state_d       = bwgt_pkg::S_QMUL;
					end else begin
						cmd.load_pose = 1'b1;
					end
				end
			end
			bwgt_pkg::S_QMUL: begin
				cmd.mul_go = (cnt_q != LAST_MUL);
				cnt_clr    = (cnt_q == LAST_MUL);
				if (cnt_q == LAST_MUL)
					state_d = bwgt_pkg::S_MAT;
			end
			bwgt_pkg::S_MAT: begin
				cmd.mat = 1'b1;
				state_d = bwgt_pkg::S_VMUL;
			end
			bwgt_pkg::S_VMUL: begin
				cmd.mul_go  = (cnt_q != LAST_MUL);
				cmd.mul_vec = 1'b1;
				cnt_clr     = (cnt_q == LAST_MUL);
				if (cnt_q == LAST_MUL)
					state_d = bwgt_pkg::S_FIN;
			end
			bwgt_pkg::S_FIN: begin
				cmd.fin = 1'b1;
				state_d = bwgt_pkg::S_CINIT;
			end
			bwgt_pkg::S_CINIT: begin
				cmd.cinit = 1'b1;
				state_d   = bwgt_pkg::S_CITER;
			end
			bwgt_pkg::S_CITER: begin
				cmd.citer = 1'b1;
				cnt_clr   = (cnt_q == LAST_STEP);
				if (cnt_q == LAST_STEP)
					state_d = bwgt_pkg::S_YAW;
			end
			bwgt_pkg::S_YAW: begin
				cmd.yaw = 1'b1;
				state_d = bwgt_pkg::S_HOLD;
			end
			bwgt_pkg::S_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = bwgt_pkg::S_IDLE;
				end
			end
			default: state_d = bwgt_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bwgt_pkg::S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_clr ? '0 : cnt_q + 1'b1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`BWGT_ASSERT(a_move_starts, (in_valid && in_ready && in_command) |=> (state_q == bwgt_pkg::S_QMUL), "move beat did not start products")
	`BWGT_ASSERT(a_handoff, cmd.load_out |=> out_valid_q, "result not presented after handoff")
	`BWGT_NEVER(a_mul_cnt, ((state_q == bwgt_pkg::S_QMUL || state_q == bwgt_pkg::S_VMUL) && cnt_q > LAST_MUL), "product counter overran")

endmodule

// ===== design/bwgt_dp.sv =====
// ----------------------------------------------------------------------------
// bwgt_dp
// pose store, shared multiplier, matrix, accumulators and cordic
// ----------------------------------------------------------------------------
module bwgt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  bwgt_pkg::cmd_t     cmd,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [31:0] pose_z,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [31:0] step_x,
	input  logic signed [31:0] step_y,
	input  logic signed [31:0] step_z,
	input  logic signed [15:0] step_yaw,
	output logic signed [31:0] goal_x,
	output logic signed [31:0] goal_y,
	output logic signed [31:0] goal_z,
	output logic signed [15:0] goal_yaw,
	output logic               saturated
);

	localparam int RF_W  = bwgt_pkg::RF_W;
	localparam int CV_W  = bwgt_pkg::CV_W;
	localparam int CZ_W  = bwgt_pkg::CZ_W;
	localparam int ACC_W = bwgt_pkg::ACC_W;

	logic signed [31:0] pos_q [3];
	logic signed [15:0] quat_q [4];
	logic signed [31:0] step_q [3];
	logic signed [15:0] syaw_q;

	logic signed [31:0]      prod_q [bwgt_pkg::NUM_PROD];
	logic signed [31:0]      rq_q   [bwgt_pkg::NUM_PROD];
	logic signed [ACC_W-1:0] acc_q  [3];
	logic signed [RF_W-1:0]  cos_q, sin_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p_s1;
	logic               mul_vld_s1, mul_vec_s1;
	logic [3:0]         mul_idx_s1;
	logic [3:0]         k;
	logic [3:0]         qp;

	logic signed [31:0] goal_q [3];
	logic               sat_q;
	logic signed [CV_W-1:0] cx_q, cy_q;
	logic signed [CZ_W-1:0] cz_q;
	logic                   czero_q;
	logic signed [15:0]     yaw_q;

	logic signed [31:0] out_q [3];
	logic signed [15:0] out_yaw_q;
	logic               out_sat_q;

	// shared 32x32 multiplier operand select
	always_comb begin
		k  = cmd.idx[3:0];
		qp = bwgt_pkg::qpair(k);
		if (cmd.mul_vec) begin
			mul_a = rq_q[k];
			mul_b = step_q[bwgt_pkg::col_of(k)];
		end else begin
			mul_a = 32'(quat_q[qp[3:2]]);
			mul_b = 32'(quat_q[qp[1:0]]);
		end
	end

	// rotation entries in q28
	logic signed [RF_W-1:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
	logic signed [RF_W-1:0] r [bwgt_pkg::NUM_PROD];
	always_comb begin
		pxx = RF_W'(prod_q[0]); pyy = RF_W'(prod_q[1]); pzz = RF_W'(prod_q[2]);
		pxy = RF_W'(prod_q[3]); pxz = RF_W'(prod_q[4]); pyz = RF_W'(prod_q[5]);
		pwx = RF_W'(prod_q[6]); pwy = RF_W'(prod_q[7]); pwz = RF_W'(prod_q[8]);
		r[0] = bwgt_pkg::ONE_Q28 - ((pyy + pzz) <<< 1);
		r[1] = (pxy - pwz) <<< 1;
		r[2] = (pxz + pwy) <<< 1;
		r[3] = (pxy + pwz) <<< 1;
		r[4] = bwgt_pkg::ONE_Q28 - ((pxx + pzz) <<< 1);
		r[5] = (pyz - pwx) <<< 1;
		r[6] = (pxz - pwy) <<< 1;
		r[7] = (pyz + pwx) <<< 1;
		r[8] = bwgt_pkg::ONE_Q28 - ((pxx + pyy) <<< 1);
	end

	// rounding, add to position and clamp
	logic signed [ACC_W-1:0] acc_rnd [3];
	logic signed [40:0]      gsum [3];
	logic signed [31:0]      gclip [3];
	logic [2:0]              gsat;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_rnd[i] = acc_q[i] + ACC_W'(64'sd8388608);
			gsum[i]    = 41'(pos_q[i]) + 41'(acc_rnd[i] >>> 24);
			gsat[i]    = 1'b1;
			if (gsum[i] > 41'sd2147483647)
				gclip[i] = 32'sh7fffffff;
			else if (gsum[i] < -41'sd2147483648)
				gclip[i] = 32'sh80000000;
			else begin
				gclip[i] = gsum[i][31:0];
				gsat[i]  = 1'b0;
			end
		end
	end

	// cordic vectoring step
	logic signed [CV_W-1:0] dx, dy;
	logic signed [CZ_W-1:0] at;
	logic signed [CV_W-1:0] sx0, sy0;
	always_comb begin
		dx  = cy_q >>> cmd.idx;
		dy  = cx_q >>> cmd.idx;
		at  = bwgt_pkg::atan_q24(cmd.idx);
		sx0 = CV_W'(cos_q);
		sy0 = CV_W'(sin_q);
	end

	// angle rounding, clamp and wrap
	logic signed [CZ_W-1:0] zr;
	logic signed [17:0]     ang, ysum;
	always_comb begin
		zr  = cz_q + CZ_W'(1024);
		ang = 18'(zr >>> 11);
		if (ang > bwgt_pkg::PI_Q13)
			ang = bwgt_pkg::PI_Q13;
		else if (ang < -bwgt_pkg::PI_Q13)
			ang = -bwgt_pkg::PI_Q13;
		if (czero_q)
			ang = '0;
		ysum = ang + 18'(syaw_q);
		if (ysum > bwgt_pkg::PI_Q13)
			ysum = ysum - bwgt_pkg::TWO_PI_Q13;
		else if (ysum < -bwgt_pkg::PI_Q13)
			ysum = ysum + bwgt_pkg::TWO_PI_Q13;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '{default: '0};
			quat_q     <= '{default: '0};
			mul_vld_s1 <= 1'b0;
		end else begin
			mul_vld_s1 <= cmd.mul_go;
			if (cmd.load_pose) begin
				pos_q[0]  <= pose_x;
				pos_q[1]  <= pose_y;
				pos_q[2]  <= pose_z;
				quat_q[0] <= quat_w;
				quat_q[1] <= quat_x;
				quat_q[2] <= quat_y;
				quat_q[3] <= quat_z;
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_p_s1   <= mul_a * mul_b;
		mul_vec_s1 <= cmd.mul_vec;
		mul_idx_s1 <= k;
		if (cmd.load_step) begin
			step_q[0] <= step_x;
			step_q[1] <= step_y;
			step_q[2] <= step_z;
			syaw_q    <= step_yaw;
		end
		if (mul_vld_s1) begin
			if (mul_vec_s1)
				acc_q[bwgt_pkg::row_of(mul_idx_s1)] <=
					acc_q[bwgt_pkg::row_of(mul_idx_s1)] + mul_p_s1;
			else
				prod_q[mul_idx_s1] <= mul_p_s1[31:0];
		end
		if (cmd.mat) begin
			for (int i = 0; i < bwgt_pkg::NUM_PROD; i++)
				rq_q[i] <= 32'((r[i] + RF_W'(8)) >>> 4);
			acc_q <= '{default: '0};
			cos_q <= r[0];
			sin_q <= r[3];
		end
		if (cmd.fin) begin
			goal_q <= gclip;
			sat_q  <= |gsat;
		end
		if (cmd.cinit) begin
			czero_q <= (cos_q == '0) && (sin_q == '0);
			if (cos_q < 0) begin
				if (sin_q >= 0) begin
					cx_q <= sy0;
					cy_q <= -sx0;
					cz_q <= bwgt_pkg::atan_q24('0) <<< 1;
				end else begin
					cx_q <= -sy0;
					cy_q <= sx0;
					cz_q <= -(bwgt_pkg::atan_q24('0) <<< 1);
				end
			end else begin
				cx_q <= sx0;
				cy_q <= sy0;
				cz_q <= '0;
			end
		end
		if (cmd.citer) begin
			if (cy_q > 0) begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + at;
			end else begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - at;
			end
		end
		if (cmd.yaw)
			yaw_q <= ysum[15:0];
		if (cmd.load_out) begin
			out_q     <= goal_q;
			out_yaw_q <= yaw_q;
			out_sat_q <= sat_q;
		end
	end

	assign goal_x    = out_q[0];
	assign goal_y    = out_q[1];
	assign goal_z    = out_q[2];
	assign goal_yaw  = out_yaw_q;
	assign saturated = out_sat_q;

endmodule

// ===== design/body_to_world_goal_transform_unit.sv =====
// ----------------------------------------------------------------------------
// body_to_world_goal_transform_unit
// rotates a body-frame step into the world frame and adds odometry yaw
// ----------------------------------------------------------------------------
//  channel   role    payload
//  in_ch     sink    command, pose, quaternion, step, yaw offset
//  out_ch    source  goal x/y/z, goal yaw, saturated
//
// an odometry beat is taken while idle and stores the pose
// a move beat runs two passes through the one shared 32x32 multiplier (9 quaternion
// products, then 9 rotation products, each pass ending in a drain), four steps
// (matrix, finish, cordic init, yaw) and the cordic loop of one step a cycle,
// and its result is then presented on out_ch
// the unit takes no new beat while a move runs; the next is taken once it is idle
// a finished result waits in an output register; odometry beats are still taken
// while out_ch stalls, a further move runs and then holds until that register frees
// reset clears the stored pose to zero (identity rotation, yaw 0)
// ----------------------------------------------------------------------------
module body_to_world_goal_transform_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bwgt_in_if.sink     in_ch,
	bwgt_out_if.source  out_ch
);

	bwgt_pkg::cmd_t cmd;

	// sequencer: accepts beats, runs the product, matrix and cordic phases
	bwgt_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_command(in_ch.command),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.cmd       (cmd)
	);

	// datapath: pose store, multiplier, accumulators, cordic, output register
	bwgt_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.pose_x   (in_ch.pose_x),
		.pose_y   (in_ch.pose_y),
		.pose_z   (in_ch.pose_z),
		.quat_w   (in_ch.quat_w),
		.quat_x   (in_ch.quat_x),
		.quat_y   (in_ch.quat_y),
		.quat_z   (in_ch.quat_z),
		.step_x   (in_ch.step_x),
		.step_y   (in_ch.step_y),
		.step_z   (in_ch.step_z),
		.step_yaw (in_ch.step_yaw),
		.goal_x   (out_ch.goal_x),
		.goal_y   (out_ch.goal_y),
		.goal_z   (out_ch.goal_z),
		.goal_yaw (out_ch.goal_yaw),
		.saturated(out_ch.saturated)
	);

endmodule
